FILE: design/cvf_pkg.sv
// ----------------------------------------------------------------------------
// cvf_pkg
// shared types and constants of the 3x3 convolution filter
// ----------------------------------------------------------------------------
package cvf_pkg;

    localparam int DIM_W       = 9;
    localparam int PIX_W       = 8;
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int QUEUE_DEPTH = 2;
    localparam int ACC_W       = 21;
    localparam int PROD_W      = 17;
    localparam int MAG_W       = 20;
    localparam int TAPS        = 9;

    localparam logic [DIM_W-1:0] MIN_DIM     = 9'd3;
    localparam logic [DIM_W-1:0] WIDTH_RST   = 9'd160;
    localparam logic [DIM_W-1:0] HEIGHT_RST  = 9'd120;
    localparam logic [PIX_W-1:0] PIX_MAX     = 8'd255;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_COEF_TOP     = 3'd2,
        REG_COEF_MID     = 3'd3,
        REG_COEF_BOT     = 3'd4,
        REG_SUM_DIVISOR  = 3'd5
    } reg_idx_t;

    typedef enum logic {
        F_IDLE,
        F_READ
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MAC,
        B_ACC,
        B_DIV,
        B_CLAMP,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        logic [TAPS-1:0][PIX_W-1:0] win;
        logic [DIM_W-1:0]           x;
        logic [DIM_W-1:0]           y;
        logic                       emit_main;
        logic                       border;
        logic                       last_col;
        logic                       last_row;
        logic                       x_nz;
    } job_t;

    typedef struct packed {
        logic [PIX_W-1:0] row;
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] pix;
        logic             done;
    } res_t;

    typedef struct packed {
        logic [TAPS-1:0][PIX_W-1:0] coef;
        logic signed [PIX_W-1:0]    divisor;
    } filt_cfg_t;

endpackage

FILE: design/cvf_fifo.sv
// ----------------------------------------------------------------------------
// cvf_fifo
// small register queue with full and empty flags
// ----------------------------------------------------------------------------
module cvf_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int DEPTH = cvf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        full        = (cnt_reg == CNT_W'(DEPTH));
        empty       = (cnt_reg == '0);
        do_push     = push && !full;
        do_pop      = pop && !empty;
        rdata       = mem_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: design/cvf_front.sv
// ----------------------------------------------------------------------------
// cvf_front
// pixel intake: line stores, 3x3 window and result classification
// ----------------------------------------------------------------------------
module cvf_front #(
    parameter int MAX_WIDTH = cvf_pkg::MAX_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [cvf_pkg::PIX_W-1:0]   pixel_in,
    input  logic [cvf_pkg::DIM_W-1:0]   frame_width,
    input  logic [cvf_pkg::DIM_W-1:0]   frame_height,
    output logic                        job_push,
    output cvf_pkg::job_t               job,
    input  logic                        job_full
);

    localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DIM_W = cvf_pkg::DIM_W;
    localparam int PIX_W = cvf_pkg::PIX_W;
    localparam int TAPS  = cvf_pkg::TAPS;

    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] lower_mem [MAX_WIDTH];

    cvf_pkg::front_state_t state_reg, state_next;
    logic [DIM_W-1:0]            x_reg, x_next;
    logic [DIM_W-1:0]            y_reg, y_next;
    logic [TAPS-1:0][PIX_W-1:0]  win_reg, win_next;
    logic [PIX_W-1:0]            pix_reg;
    logic [PIX_W-1:0]            up_rd_reg;
    logic [PIX_W-1:0]            lo_rd_reg;

    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [AW-1:0]    xi;
    logic             last_col;
    logic             last_row;
    logic             accept;
    logic             step;

    always_comb
    begin
        if (frame_width < cvf_pkg::MIN_DIM)
        begin
            w = cvf_pkg::MIN_DIM;
        end
        else if (32'(frame_width) > 32'(MAX_WIDTH))
        begin
            w = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            w = frame_width;
        end
        if (frame_height < cvf_pkg::MIN_DIM)
        begin
            h = cvf_pkg::MIN_DIM;
        end
        else if (32'(frame_height) > 32'(cvf_pkg::MAX_HEIGHT))
        begin
            h = DIM_W'(cvf_pkg::MAX_HEIGHT);
        end
        else
        begin
            h = frame_height;
        end
        if (32'(x_reg) < 32'(MAX_WIDTH))
        begin
            xi = AW'(x_reg);
        end
        else
        begin
            xi = AW'(MAX_WIDTH - 1);
        end
        last_col = (({1'b0, x_reg} + 10'd1) >= {1'b0, w});
        last_row = (({1'b0, y_reg} + 10'd1) >= {1'b0, h});
    end

    // window shift, new column enters on the right
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r * 3]     = win_reg[r * 3 + 1];
            win_next[r * 3 + 1] = win_reg[r * 3 + 2];
        end
        win_next[2] = up_rd_reg;
        win_next[5] = lo_rd_reg;
        win_next[8] = pix_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        full       = 1'b0;
        job_push   = 1'b0;
        accept     = 1'b0;
        step       = 1'b0;
        x_next     = x_reg;
        y_next     = y_reg;
        case (state_reg)
            cvf_pkg::F_IDLE:
            begin
                accept = push;
                if (push)
                begin
                    state_next = cvf_pkg::F_READ;
                end
            end
            cvf_pkg::F_READ:
            begin
                full = 1'b1;
                if (!job_full)
                begin
                    step       = 1'b1;
                    job_push   = 1'b1;
                    state_next = cvf_pkg::F_IDLE;
                    if (last_col)
                    begin
                        x_next = '0;
                        y_next = last_row ? '0 : y_reg + 1'b1;
                    end
                    else
                    begin
                        x_next = x_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = cvf_pkg::F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        job.win       = win_next;
        job.x         = x_reg;
        job.y         = y_reg;
        job.emit_main = (y_reg != '0) && (x_reg != '0);
        job.border    = (y_reg == DIM_W'(1)) || (x_reg == DIM_W'(1))
                        || (x_reg >= w) || (y_reg >= h);
        job.last_col  = last_col;
        job.last_row  = last_row;
        job.x_nz      = (x_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_rd_reg <= upper_mem[xi];
            lo_rd_reg <= lower_mem[xi];
            pix_reg   <= pixel_in;
        end
        if (step)
        begin
            upper_mem[xi] <= lo_rd_reg;
            lower_mem[xi] <= pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cvf_pkg::F_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            win_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            if (step)
            begin
                win_reg <= win_next;
            end
        end
    end

endmodule

FILE: design/cvf_back.sv
// ----------------------------------------------------------------------------
// cvf_back
// window sum over a shared multiplier, serial divider, result sequencing
// ----------------------------------------------------------------------------
module cvf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_empty,
    output logic                job_pop,
    input  cvf_pkg::job_t       job,
    input  cvf_pkg::filt_cfg_t  cfg,
    output logic                res_push,
    output cvf_pkg::res_t       res,
    input  logic                res_full
);

    localparam int ACC_W  = cvf_pkg::ACC_W;
    localparam int PROD_W = cvf_pkg::PROD_W;
    localparam int MAG_W  = cvf_pkg::MAG_W;
    localparam int PIX_W  = cvf_pkg::PIX_W;
    localparam int DIM_W  = cvf_pkg::DIM_W;
    localparam int K_W    = $clog2(cvf_pkg::TAPS);
    localparam int STEP_W = $clog2(MAG_W);

    cvf_pkg::back_state_t state_reg, state_next;
    cvf_pkg::job_t         job_reg, job_next;
    logic [K_W-1:0]        k_reg, k_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [PIX_W-1:0]      rem_reg, rem_next;
    logic [MAG_W-1:0]      dvd_reg, dvd_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [PIX_W-1:0]      filt_reg, filt_next;
    logic [1:0]            slot_reg, slot_next;

    logic signed [ACC_W-1:0] sum;
    logic [ACC_W-1:0]        sum_abs;
    logic [PIX_W-1:0]        dmag;
    logic [PIX_W:0]          trial;
    logic [DIM_W-1:0]        xm1;
    logic [DIM_W-1:0]        ym1;
    logic                    present;

    always_comb
    begin
        sum     = acc_reg + ACC_W'(prod_reg);
        sum_abs = sum[ACC_W-1] ? ACC_W'(-sum) : sum;
        dmag    = cfg.divisor[PIX_W-1] ? PIX_W'(-cfg.divisor) : cfg.divisor;
        trial   = {rem_reg, dvd_reg[MAG_W-1]};
        xm1     = job_reg.x - 1'b1;
        ym1     = job_reg.y - 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        k_next     = k_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        step_next  = step_reg;
        filt_next  = filt_reg;
        slot_next  = slot_reg;
        job_pop    = 1'b0;
        res_push   = 1'b0;
        res        = '0;
        present    = 1'b0;
        case (state_reg)
            cvf_pkg::B_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop   = 1'b1;
                    job_next  = job;
                    k_next    = '0;
                    acc_next  = '0;
                    slot_next = '0;
                    if (job.emit_main && !job.border)
                    begin
                        state_next = cvf_pkg::B_MAC;
                    end
                    else
                    begin
                        state_next = cvf_pkg::B_EMIT;
                    end
                end
            end
            cvf_pkg::B_MAC:
            begin
                prod_next = $signed({1'b0, job_reg.win[k_reg]}) * $signed(cfg.coef[k_reg]);
                if (k_reg != '0)
                begin
                    acc_next = sum;
                end
                if (k_reg == K_W'(cvf_pkg::TAPS - 1))
                begin
                    state_next = cvf_pkg::B_ACC;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            cvf_pkg::B_ACC:
            begin
                state_next = cvf_pkg::B_EMIT;
                if (cfg.divisor == '0)
                begin
                    if (sum[ACC_W-1])
                    begin
                        filt_next = '0;
                    end
                    else if (sum > ACC_W'(cvf_pkg::PIX_MAX))
                    begin
                        filt_next = cvf_pkg::PIX_MAX;
                    end
                    else
                    begin
                        filt_next = sum[PIX_W-1:0];
                    end
                end
                else if ((sum != '0) && (sum[ACC_W-1] == cfg.divisor[PIX_W-1]))
                begin
                    // positive quotient, divide magnitudes
                    dvd_next   = sum_abs[MAG_W-1:0];
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = cvf_pkg::B_DIV;
                end
                else
                begin
                    // zero or negative quotient clamps to zero
                    filt_next = '0;
                end
            end
            cvf_pkg::B_DIV:
            begin
                if (trial >= {1'b0, dmag})
                begin
                    rem_next = PIX_W'(trial - {1'b0, dmag});
                    dvd_next = {dvd_reg[MAG_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[PIX_W-1:0];
                    dvd_next = {dvd_reg[MAG_W-2:0], 1'b0};
                end
                if (step_reg == STEP_W'(MAG_W - 1))
                begin
                    state_next = cvf_pkg::B_CLAMP;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            cvf_pkg::B_CLAMP:
            begin
                if (dvd_reg > MAG_W'(cvf_pkg::PIX_MAX))
                begin
                    filt_next = cvf_pkg::PIX_MAX;
                end
                else
                begin
                    filt_next = dvd_reg[PIX_W-1:0];
                end
                state_next = cvf_pkg::B_EMIT;
            end
            cvf_pkg::B_EMIT:
            begin
                case (slot_reg)
                    2'd0:
                    begin
                        present  = job_reg.emit_main;
                        res.row  = ym1[PIX_W-1:0];
                        res.col  = xm1[PIX_W-1:0];
                        res.pix  = job_reg.border ? job_reg.win[4] : filt_reg;
                    end
                    2'd1:
                    begin
                        present  = job_reg.emit_main && job_reg.last_col;
                        res.row  = ym1[PIX_W-1:0];
                        res.col  = job_reg.x[PIX_W-1:0];
                        res.pix  = job_reg.win[5];
                    end
                    2'd2:
                    begin
                        present  = job_reg.last_row && job_reg.x_nz;
                        res.row  = job_reg.y[PIX_W-1:0];
                        res.col  = xm1[PIX_W-1:0];
                        res.pix  = job_reg.win[7];
                    end
                    default:
                    begin
                        present  = job_reg.last_row && job_reg.last_col && job_reg.x_nz;
                        res.row  = job_reg.y[PIX_W-1:0];
                        res.col  = job_reg.x[PIX_W-1:0];
                        res.pix  = job_reg.win[8];
                        res.done = 1'b1;
                    end
                endcase
                if (!present || !res_full)
                begin
                    res_push = present;
                    if (slot_reg == 2'd3)
                    begin
                        state_next = cvf_pkg::B_IDLE;
                    end
                    else
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = cvf_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cvf_pkg::B_IDLE;
            k_reg     <= '0;
            step_reg  <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            step_reg  <= step_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        filt_reg <= filt_next;
    end

endmodule

FILE: design/conv3x3_image_filter.sv
// result path: a border pixel is copied; a filtered pixel takes nine multiply-accumulate steps
//   on one shared multiplier, then 20 divider steps for a positive quotient with a nonzero divisor
// intake: one pixel at a time, line store read then write; the next pixel waits
//   until the window has been handed to the job queue
// reset: asynchronous, active low; counters, window and configuration registers return
//   to defaults, line stores are not cleared
// ----------------------------------------------------------------------------
// conv3x3_image_filter
// 3x3 convolution over a raster pixel stream with two line stores
// ----------------------------------------------------------------------------
module conv3x3_image_filter #(
    parameter int MAX_WIDTH = cvf_pkg::MAX_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  pixel_in,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_row,
    output logic [7:0]  out_col,
    output logic [7:0]  pixel_out,
    output logic        frame_done,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DIM_W = cvf_pkg::DIM_W;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [23:0]      coef_top_reg;
    logic [23:0]      coef_mid_reg;
    logic [23:0]      coef_bot_reg;
    logic [7:0]       divisor_reg;
    logic             cfg_wr;
    cvf_pkg::reg_idx_t cfg_idx;

    cvf_pkg::job_t      job_in;
    cvf_pkg::job_t      job_out;
    logic               job_push;
    logic               job_full;
    logic               job_pop;
    logic               job_empty;
    cvf_pkg::res_t      res_in;
    cvf_pkg::res_t      res_out;
    logic               res_push;
    logic               res_full;
    cvf_pkg::filt_cfg_t fcfg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = cvf_pkg::reg_idx_t'(paddr[4:2]);

    always_comb
    begin
        case (cfg_idx)
            cvf_pkg::REG_FRAME_WIDTH:  prdata = 32'(width_reg);
            cvf_pkg::REG_FRAME_HEIGHT: prdata = 32'(height_reg);
            cvf_pkg::REG_COEF_TOP:     prdata = 32'(coef_top_reg);
            cvf_pkg::REG_COEF_MID:     prdata = 32'(coef_mid_reg);
            cvf_pkg::REG_COEF_BOT:     prdata = 32'(coef_bot_reg);
            cvf_pkg::REG_SUM_DIVISOR:  prdata = 32'(divisor_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= cvf_pkg::WIDTH_RST;
            height_reg   <= cvf_pkg::HEIGHT_RST;
            coef_top_reg <= '0;
            coef_mid_reg <= '0;
            coef_bot_reg <= '0;
            divisor_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                cvf_pkg::REG_FRAME_WIDTH:  width_reg    <= pwdata[DIM_W-1:0];
                cvf_pkg::REG_FRAME_HEIGHT: height_reg   <= pwdata[DIM_W-1:0];
                cvf_pkg::REG_COEF_TOP:     coef_top_reg <= pwdata[23:0];
                cvf_pkg::REG_COEF_MID:     coef_mid_reg <= pwdata[23:0];
                cvf_pkg::REG_COEF_BOT:     coef_bot_reg <= pwdata[23:0];
                cvf_pkg::REG_SUM_DIVISOR:  divisor_reg  <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    assign fcfg.coef    = {coef_bot_reg, coef_mid_reg, coef_top_reg};
    assign fcfg.divisor = divisor_reg;

    cvf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel_in     (pixel_in),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .job_push     (job_push),
        .job          (job_in),
        .job_full     (job_full)
    );

    cvf_fifo #(
        .WIDTH ($bits(cvf_pkg::job_t))
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .rdata (job_out),
        .empty (job_empty)
    );

    cvf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .job       (job_out),
        .cfg       (fcfg),
        .res_push  (res_push),
        .res       (res_in),
        .res_full  (res_full)
    );

    cvf_fifo #(
        .WIDTH ($bits(cvf_pkg::res_t))
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign out_row    = res_out.row;
    assign out_col    = res_out.col;
    assign pixel_out  = res_out.pix;
    assign frame_done = res_out.done;

`ifndef SYNTHESIS
    a_job_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(job_push && job_full))
        else $error("job transfer into full queue");

    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_push && res_full))
        else $error("result transfer into full queue");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("intake not busy after pixel transfer");
`endif

endmodule
